### sv/lstk_pkg.sv
package lstk_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [2:0] {
    OP_PUSH        = 3'd0,
    OP_POP         = 3'd1,
    OP_PEEK_TOP    = 3'd2,
    OP_PEEK_BOTTOM = 3'd3,
    OP_NEXT        = 3'd4
  } op_t;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic step;  // execute the operation on the input beat
    logic load;  // move the pending result into the output register
  } cmd_t;

endpackage

### sv/lifo_stack_with_iterator.sv
// LIFO stack of data words with a walk index.
// Input channel (in_*): one beat is one operation. in_tuser carries the
// operation (push, pop, peek top, peek bottom, next), in_tdata the word
// stored by a push. Result channel (out_*): exactly one beat per operation,
// in order, carrying the returned word, status, count and empty/full flags.
// Peek top/bottom set the walk index and next advances it toward the top;
// next past the top or a pop/peek on an empty stack returns status "none".
// The result passes the pending-read stage and then the output register
// before out_tvalid rises; the entry store is a single-port RAM with a
// registered read. Throughput: one operation per cycle while results
// are taken; the pending-read stage and the output register let a new
// beat in while a result still waits.
// Stall: when out_tready stays low with a result held and another pending,
// in_tready drops and both hold until the result is taken.
// Reset (rst_n low, synchronous): the stack empties, the walk index goes to
// zero and no result is shown. Entry contents are not cleared; only written
// entries are ever read back.
module lifo_stack_with_iterator #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [DATA_WIDTH-1:0] push_data, zero padded to whole bytes
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // [2:0] func
  input  logic [lstk_pkg::FUNC_W-1:0]           in_tuser,

  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // from bit 0 up: data_out, status (2), count, is_empty, is_full; zero pad
  output logic [((DATA_WIDTH + $clog2(DEPTH + 1) + 4 + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W  = DATA_WIDTH + CW + 4;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

  lstk_pkg::cmd_t cmd;

  logic [DATA_WIDTH-1:0]         data_out;
  logic [lstk_pkg::STATUS_W-1:0] status;
  logic [CW-1:0]                 count;
  logic                          is_empty;
  logic                          is_full;

  lstk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  lstk_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .func      (in_tuser),
    .push_data (in_tdata[DATA_WIDTH-1:0]),
    .data_out  (data_out),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  // Pack result fields from the lowest bit up
  assign out_tdata = OUT_TW'({is_full, is_empty, count, status, data_out});

endmodule

### sv/lstk_ram.sv
module lstk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/lstk_ctrl.sv
module lstk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output lstk_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_LOOKUP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load;
  logic   step;

  // Pending result may move out when the output register is empty or draining
  assign load      = (state_r == S_LOOKUP) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE) || load;
  assign step      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (step) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (load && !step) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign cmd.step   = step;
  assign cmd.load   = load;

endmodule

### sv/lstk_dp.sv
module lstk_dp #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lstk_pkg::cmd_t                    cmd,
  input  logic [lstk_pkg::FUNC_W-1:0]       func,
  input  logic [DATA_WIDTH-1:0]             push_data,
  output logic [DATA_WIDTH-1:0]             data_out,
  output logic [lstk_pkg::STATUS_W-1:0]     status,
  output logic [$clog2(DEPTH+1)-1:0]        count,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = AW + 1;

  logic [CW-1:0]        fill_r, fill_nxt;
  logic signed [WW-1:0] walk_r, walk_nxt;

  logic [WW-1:0] fill_ext;
  logic [WW-1:0] fill_m1;
  logic [WW-1:0] walk_inc;
  logic          empty_now;
  logic          full_now;

  logic                          ram_we;
  logic                          ram_re;
  logic [AW-1:0]                 ram_addr;
  logic [DATA_WIDTH-1:0]         ram_rdata;
  logic [lstk_pkg::STATUS_W-1:0] st_nxt;
  logic                          use_ram;

  // Pending stage: holds status and count beside the registered RAM read
  logic [lstk_pkg::STATUS_W-1:0] p_status_r;
  logic [CW-1:0]                 p_count_r;
  logic                          p_use_r;

  logic [DATA_WIDTH-1:0]         out_data_r;
  logic [lstk_pkg::STATUS_W-1:0] out_status_r;
  logic [CW-1:0]                 out_count_r;
  logic                          out_empty_r;
  logic                          out_full_r;

  assign fill_ext  = WW'(fill_r);
  assign fill_m1   = fill_ext - WW'(1);
  assign walk_inc  = $unsigned(walk_r) + WW'(1);
  assign empty_now = (fill_r == '0);
  assign full_now  = (fill_r == CW'(DEPTH));

  always_comb begin
    fill_nxt = fill_r;
    walk_nxt = walk_r;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = fill_m1[AW-1:0];
    st_nxt   = lstk_pkg::ST_OK;
    use_ram  = 1'b0;
    case (func)
      lstk_pkg::OP_PUSH: begin
        ram_addr = fill_ext[AW-1:0];
        if (full_now) begin
          st_nxt = lstk_pkg::ST_FULL;
        end else begin
          ram_we   = cmd.step;
          fill_nxt = fill_r + CW'(1);
        end
      end
      lstk_pkg::OP_POP: begin
        if (empty_now) begin
          st_nxt = lstk_pkg::ST_NONE;
        end else begin
          ram_re   = cmd.step;
          use_ram  = 1'b1;
          fill_nxt = fill_r - CW'(1);
        end
      end
      lstk_pkg::OP_PEEK_TOP: begin
        walk_nxt = $signed(fill_m1);
        if (empty_now) begin
          st_nxt = lstk_pkg::ST_NONE;
        end else begin
          ram_re  = cmd.step;
          use_ram = 1'b1;
        end
      end
      lstk_pkg::OP_PEEK_BOTTOM: begin
        walk_nxt = '0;
        ram_addr = '0;
        if (empty_now) begin
          st_nxt = lstk_pkg::ST_NONE;
        end else begin
          ram_re  = cmd.step;
          use_ram = 1'b1;
        end
      end
      lstk_pkg::OP_NEXT: begin
        ram_addr = walk_inc[AW-1:0];
        // walk + 1 is never negative, so an unsigned compare is exact
        if (walk_inc >= fill_ext) begin
          st_nxt = lstk_pkg::ST_NONE;
        end else begin
          walk_nxt = $signed(walk_inc);
          ram_re   = cmd.step;
          use_ram  = 1'b1;
        end
      end
      default: st_nxt = lstk_pkg::ST_NONE;
    endcase
  end

  lstk_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (push_data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      walk_r <= '0;
    end else if (cmd.step) begin
      fill_r <= fill_nxt;
      walk_r <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      p_status_r <= st_nxt;
      p_count_r  <= fill_nxt;
      p_use_r    <= use_ram;
    end
    if (cmd.load) begin
      out_data_r   <= p_use_r ? ram_rdata : '0;
      out_status_r <= p_status_r;
      out_count_r  <= p_count_r;
      out_empty_r  <= (p_count_r == '0);
      out_full_r   <= (p_count_r == CW'(DEPTH));
    end
  end

  assign data_out = out_data_r;
  assign status   = out_status_r;
  assign count    = out_count_r;
  assign is_empty = out_empty_r;
  assign is_full  = out_full_r;

endmodule

### tb/lifo_stack_with_iterator_tb.sv
module lifo_stack_with_iterator_tb;
  import lstk_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned IN_W       = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_W      = ((DATA_WIDTH + CNT_W + 4 + 7) / 8) * 8;

  // func codes that map to no operation; the block must answer "none"
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 300;  // per idling phase
  localparam int LONG_HOLD    = 150;  // receiver hold-off, in cycles
  localparam int TAIL_CYCLES  = 8;    // run on after the last result is back; leave slack
  localparam int PRINT_CAP    = 40;

  // One result beat, unpacked into its fields
  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic [STATUS_W-1:0]   status;
    logic [CNT_W-1:0]      count;
    logic                  is_empty;
    logic                  is_full;
  } result_t;

  // One row of the directed plan. reps > 1 repeats the op with random words;
  // known set means the expected result is typed into the row.
  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [DATA_WIDTH-1:0] word;
    logic [6:0]            reps;
    logic                  known;
    result_t               want;
  } plan_row_t;

  localparam int PLAN_LEN = 26;

  logic clk;
  logic rst_n;

  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;   // [31:0] push_data
  logic [FUNC_W-1:0]    in_tuser;   // [2:0] func

  logic                 out_tvalid;
  logic                 out_tready;
  // [31:0] data_out, [33:32] status, [40:34] count, [41] is_empty,
  // [42] is_full, rest zero
  logic [OUT_W-1:0]     out_tdata;

  // Stack image kept by the predictor
  logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
  int                    shadow_fill;
  int                    shadow_walk;   // signed, may sit at -1

  result_t results_due [$];
  int      err_count;
  int      tx_idle_pct;
  int      rx_idle_pct;
  int      hold_request;

  // Directed plan: empty-stack corners, the walk index at -1 and past the top,
  // a stale walk index after a pop, unused codes, fill to full and drain.
  plan_row_t plan [0:PLAN_LEN-1] = '{
    '{OP_POP,         32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd0,  1'b1, 1'b0}},
    '{OP_PEEK_TOP,    32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd0,  1'b1, 1'b0}},
    '{OP_NEXT,        32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd0,  1'b1, 1'b0}},
    '{OP_PEEK_BOTTOM, 32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd0,  1'b1, 1'b0}},
    '{OP_NEXT,        32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd0,  1'b1, 1'b0}},
    '{FUNC_UNUSED_LO, 32'hFFFFFFFF, 7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd0,  1'b1, 1'b0}},
    '{FUNC_UNUSED_HI, 32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd0,  1'b1, 1'b0}},
    '{OP_PUSH,        32'hFFFFFFFF, 7'd1,  1'b1, '{32'h0,        ST_OK,   7'd1,  1'b0, 1'b0}},
    '{OP_PUSH,        32'h0,        7'd1,  1'b1, '{32'h0,        ST_OK,   7'd2,  1'b0, 1'b0}},
    '{OP_PEEK_TOP,    32'h0,        7'd1,  1'b1, '{32'h0,        ST_OK,   7'd2,  1'b0, 1'b0}},
    '{OP_PEEK_BOTTOM, 32'h0,        7'd1,  1'b1, '{32'hFFFFFFFF, ST_OK,   7'd2,  1'b0, 1'b0}},
    '{OP_NEXT,        32'h0,        7'd1,  1'b1, '{32'h0,        ST_OK,   7'd2,  1'b0, 1'b0}},
    '{OP_NEXT,        32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd2,  1'b0, 1'b0}},
    '{OP_POP,         32'h0,        7'd1,  1'b1, '{32'h0,        ST_OK,   7'd1,  1'b0, 1'b0}},
    '{OP_NEXT,        32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd1,  1'b0, 1'b0}},
    '{OP_POP,         32'h0,        7'd1,  1'b1, '{32'hFFFFFFFF, ST_OK,   7'd0,  1'b1, 1'b0}},
    '{OP_PEEK_TOP,    32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd0,  1'b1, 1'b0}},
    '{OP_PUSH,        32'h5A5A5A5A, 7'd1,  1'b1, '{32'h0,        ST_OK,   7'd1,  1'b0, 1'b0}},
    '{OP_NEXT,        32'h0,        7'd1,  1'b1, '{32'h5A5A5A5A, ST_OK,   7'd1,  1'b0, 1'b0}},
    '{OP_PUSH,        32'h0,        7'd63, 1'b0, '0},
    '{OP_PUSH,        32'h12345678, 7'd1,  1'b1, '{32'h0,        ST_FULL, 7'd64, 1'b0, 1'b1}},
    '{OP_PEEK_TOP,    32'h0,        7'd1,  1'b0, '0},
    '{OP_PEEK_BOTTOM, 32'h0,        7'd1,  1'b1, '{32'h5A5A5A5A, ST_OK,   7'd64, 1'b0, 1'b1}},
    '{OP_NEXT,        32'h0,        7'd1,  1'b0, '0},
    '{OP_POP,         32'h0,        7'd64, 1'b0, '0},
    '{OP_POP,         32'h0,        7'd1,  1'b1, '{32'h0,        ST_NONE, 7'd0,  1'b1, 1'b0}}
  };

  lifo_stack_with_iterator #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the handshakes never finish
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("lifo_stack_with_iterator_tb: errors");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Apply one operation to the stack image and return the result it yields
  function automatic result_t apply_op(input logic [FUNC_W-1:0] func,
                                       input logic [DATA_WIDTH-1:0] word);
    result_t res;
    res = '0;
    res.status = ST_OK;
    case (func)
      OP_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          res.status = ST_NONE;
        end else begin
          shadow_fill--;
          res.data = shadow_words[shadow_fill];
        end
      end
      OP_PEEK_TOP: begin
        shadow_walk = shadow_fill - 1;
        if (shadow_fill == 0) res.status = ST_NONE;
        else res.data = shadow_words[shadow_walk];
      end
      OP_PEEK_BOTTOM: begin
        shadow_walk = 0;
        if (shadow_fill == 0) res.status = ST_NONE;
        else res.data = shadow_words[0];
      end
      OP_NEXT: begin
        // signed compare: a walk index of -1 still advances onto entry 0
        if (shadow_walk >= shadow_fill - 1) begin
          res.status = ST_NONE;
        end else begin
          shadow_walk++;
          res.data = shadow_words[shadow_walk];
        end
      end
      default: res.status = ST_NONE;
    endcase
    res.count    = shadow_fill[CNT_W-1:0];
    res.is_empty = (shadow_fill == 0);
    res.is_full  = (shadow_fill == DEPTH);
    return res;
  endfunction

  // Offer one beat, hold it until taken, then queue what it should return.
  // A typed expectation replaces the predicted one; the image still advances.
  task automatic send_beat(input logic [FUNC_W-1:0] func,
                           input logic [DATA_WIDTH-1:0] word,
                           input logic known, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= IN_W'(word);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_op(func, word);
    results_due.push_back(known ? want : predicted);
  endtask

  task automatic await_results;
    while (results_due.size() > 0) @(posedge clk);
  endtask

  // Random traffic in bursts: grow, shrink, walk or mixed, so the stack
  // swings between empty and full and the walk index runs across the top.
  task automatic run_random(input int n_items);
    int burst_left;
    int mode;
    int pick;
    int th [5];
    logic [FUNC_W-1:0]     func;
    logic [DATA_WIDTH-1:0] word;
    burst_left = 0;
    mode = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        mode = $urandom_range(3);
        burst_left = $urandom_range(120, 20);
      end
      burst_left--;
      case (mode)
        0: th = '{70, 78, 84, 90, 98};  // grow toward full
        1: th = '{20, 75, 82, 88, 98};  // shrink toward empty
        2: th = '{10, 18, 25, 40, 98};  // walk with next
        default: th = '{35, 60, 70, 80, 98};
      endcase
      pick = $urandom_range(99);
      if (pick < th[0]) func = OP_PUSH;
      else if (pick < th[1]) func = OP_POP;
      else if (pick < th[2]) func = OP_PEEK_TOP;
      else if (pick < th[3]) func = OP_PEEK_BOTTOM;
      else if (pick < th[4]) func = OP_NEXT;
      else func = FUNC_UNUSED_LO + FUNC_W'($urandom_range(FUNC_UNUSED_HI - FUNC_UNUSED_LO));
      case ($urandom_range(15))
        0: word = '0;
        1: word = '1;
        default: word = $urandom;
      endcase
      send_beat(func, word, 1'b0, '0);
    end
  endtask

  // Receiver: check each result beat against the oldest expectation, then
  // pick next cycle's tready; a requested hold-off is counted down here.
  initial begin : receiver
    int               hold_left;
    result_t          got;
    result_t          exp_res;
    out_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        // data_out sits in the lowest bits, is_full in the highest
        {got.is_full, got.is_empty, got.count, got.status, got.data} =
          out_tdata[$bits(result_t)-1:0];
        if (results_due.size() == 0) begin
          log_mismatch($sformatf("result beat with nothing expected, data %h", got.data));
        end else begin
          exp_res = results_due.pop_front();
          if (got.data !== exp_res.data)
            log_mismatch($sformatf("data_out %h, want %h", got.data, exp_res.data));
          if (got.status !== exp_res.status)
            log_mismatch($sformatf("status %0d, want %0d", got.status, exp_res.status));
          if (got.count !== exp_res.count)
            log_mismatch($sformatf("count %0d, want %0d", got.count, exp_res.count));
          if (got.is_empty !== exp_res.is_empty)
            log_mismatch($sformatf("is_empty %b, want %b", got.is_empty, exp_res.is_empty));
          if (got.is_full !== exp_res.is_full)
            log_mismatch($sformatf("is_full %b, want %b", got.is_full, exp_res.is_full));
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    err_count    = 0;
    hold_request = 0;
    shadow_fill  = 0;
    shadow_walk  = 0;
    // sender rarely idles, receiver mostly stalls
    tx_idle_pct  = 7;
    rx_idle_pct  = 74;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= '0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        send_beat(plan[r].func, (plan[r].reps > 1) ? DATA_WIDTH'($urandom) : plan[r].word,
                  plan[r].known, plan[r].want);
      end
    end
    run_random(RANDOM_ITEMS);

    // pause the sender until every result is back
    in_tvalid <= 1'b0;
    await_results();

    // swap: sender mostly idle, receiver rarely stalls
    tx_idle_pct = 74;
    rx_idle_pct = 7;
    run_random(RANDOM_ITEMS);

    // no idling; hold the receiver off long enough to back up the input
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = LONG_HOLD;
    run_random(RANDOM_ITEMS);

    in_tvalid <= 1'b0;
    await_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("lifo_stack_with_iterator_tb: clean");
    end else begin
      $display("lifo_stack_with_iterator_tb: errors");
    end
    $finish;
  end

endmodule

### lifo_stack_with_iterator.f
sv/lstk_pkg.sv
sv/lstk_ram.sv
sv/lstk_ctrl.sv
sv/lstk_dp.sv
sv/lifo_stack_with_iterator.sv
tb/lifo_stack_with_iterator_tb.sv
